// File: rtl/ssps_pkg.sv
// ----------------------------------------------------------------------------
// ssps_pkg
// shared widths, fixed-point helpers and series coefficients for the
// spherical shell point sampler
// ----------------------------------------------------------------------------
package ssps_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int COORD_BITS  = 24;
    localparam int RAD_BITS    = 23;
    localparam int IN_W        = 3 * FRAC_BITS;
    localparam int OUT_W       = 3 * COORD_BITS;
    localparam int CFG_IDX_W   = 1;
    localparam int PIPE_DEPTH  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_OUTER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 1'b1;

    // trig datapath: unsigned q2.56
    localparam int TW = 58;
    localparam int TF = 56;
    localparam int TH = TW / 2;
    localparam int N_TRIG = 9;
    localparam int N_CBRT = 24;
    localparam int N_SQRT = 25;
    localparam int CB_RW  = 53;
    localparam int SQ_RW  = 28;

    typedef logic [TW-1:0] t_tq;

    typedef struct packed {
        t_tq p3;
        t_tq p2;
        t_tq p1;
        t_tq p0;
    } t_pp;

    typedef struct packed {
        logic        neg;
        logic [24:0] mag;
    } t_smag;

    typedef struct packed {
        t_smag c;
        t_smag s;
    } t_ang;

    localparam logic [56:0] K_PI_HALF = 57'(64'h6487ED5110B4611A >> 6);
    localparam t_tq         K_RND     = t_tq'(1) << (TF - FRAC_BITS - 1);

    function automatic t_pp f_mul_pp(t_tq a, t_tq b);
        t_pp pp;
        pp.p0 = {{TH{1'b0}}, a[TH-1:0]} * {{TH{1'b0}}, b[TH-1:0]};
        pp.p1 = {{TH{1'b0}}, a[TH-1:0]} * {{TH{1'b0}}, b[TW-1:TH]};
        pp.p2 = {{TH{1'b0}}, a[TW-1:TH]} * {{TH{1'b0}}, b[TH-1:0]};
        pp.p3 = {{TH{1'b0}}, a[TW-1:TH]} * {{TH{1'b0}}, b[TW-1:TH]};
        return pp;
    endfunction

    function automatic t_tq f_mul_sum(t_pp pp);
        logic [2*TW-1:0] acc;
        acc = {{TW{1'b0}}, pp.p0} + ({{TW{1'b0}}, pp.p1} << TH)
            + ({{TW{1'b0}}, pp.p2} << TH) + {pp.p3, {TW{1'b0}}};
        return acc[TF+TW-1:TF];
    endfunction

    function automatic logic [127:0] f_fact(int n);
        logic [127:0] f;
        f = 128'd1;
        for (int k = 2; k <= n; k++) begin
            f = f * 128'(k);
        end
        return f;
    endfunction

    localparam logic [127:0] ONE_T = 128'd1 << TF;

    localparam logic [127:0] K_FACT [20] = '{
        f_fact(0),  f_fact(1),  f_fact(2),  f_fact(3),  f_fact(4),
        f_fact(5),  f_fact(6),  f_fact(7),  f_fact(8),  f_fact(9),
        f_fact(10), f_fact(11), f_fact(12), f_fact(13), f_fact(14),
        f_fact(15), f_fact(16), f_fact(17), f_fact(18), f_fact(19)
    };

    // 1/n! rounded to q2.56
    localparam t_tq K_COEF [20] = '{
        t_tq'((ONE_T + K_FACT[0] / 2) / K_FACT[0]),
        t_tq'((ONE_T + K_FACT[1] / 2) / K_FACT[1]),
        t_tq'((ONE_T + K_FACT[2] / 2) / K_FACT[2]),
        t_tq'((ONE_T + K_FACT[3] / 2) / K_FACT[3]),
        t_tq'((ONE_T + K_FACT[4] / 2) / K_FACT[4]),
        t_tq'((ONE_T + K_FACT[5] / 2) / K_FACT[5]),
        t_tq'((ONE_T + K_FACT[6] / 2) / K_FACT[6]),
        t_tq'((ONE_T + K_FACT[7] / 2) / K_FACT[7]),
        t_tq'((ONE_T + K_FACT[8] / 2) / K_FACT[8]),
        t_tq'((ONE_T + K_FACT[9] / 2) / K_FACT[9]),
        t_tq'((ONE_T + K_FACT[10] / 2) / K_FACT[10]),
        t_tq'((ONE_T + K_FACT[11] / 2) / K_FACT[11]),
        t_tq'((ONE_T + K_FACT[12] / 2) / K_FACT[12]),
        t_tq'((ONE_T + K_FACT[13] / 2) / K_FACT[13]),
        t_tq'((ONE_T + K_FACT[14] / 2) / K_FACT[14]),
        t_tq'((ONE_T + K_FACT[15] / 2) / K_FACT[15]),
        t_tq'((ONE_T + K_FACT[16] / 2) / K_FACT[16]),
        t_tq'((ONE_T + K_FACT[17] / 2) / K_FACT[17]),
        t_tq'((ONE_T + K_FACT[18] / 2) / K_FACT[18]),
        t_tq'((ONE_T + K_FACT[19] / 2) / K_FACT[19])
    };

endpackage

// File: rtl/spherical_shell_point_sampler.sv
// ----------------------------------------------------------------------------
// spherical_shell_point_sampler
// turns three uniform fractions into one point of a spherical shell
// ----------------------------------------------------------------------------
// Fully pipelined: one point per clock while the output is not stalled.
// The depth is set by the bit-serial cube-root and square-root cell rows
// and by the nine two-stage horner cells of the sine/cosine series. The
// whole pipeline holds while a finished result waits on m_axis_tready.
// Radius registers are sampled deep in the pipeline, so write them only
// while no request is in flight.
// ----------------------------------------------------------------------------
module spherical_shell_point_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ssps_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [ssps_pkg::RAD_BITS-1:0]     i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ssps_pkg::IN_W-1:0]         s_axis_tdata,  // u_radius, u_azimuth, u_polar
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ssps_pkg::OUT_W-1:0]        m_axis_tdata   // pos_x, pos_y, pos_z
);
    import ssps_pkg::*;

    logic                  en;
    logic [PIPE_DEPTH:1]   r_vld;
    logic [RAD_BITS-1:0]   r_outer;
    logic [RAD_BITS-1:0]   r_inner;

    // input fields
    logic [23:0] in_ur;
    logic [23:0] in_ua;
    logic [23:0] in_up;
    logic [23:0] a2;
    logic [21:0] a_rem;
    logic        n_fold;
    logic [21:0] n_rr;

    // front stages
    logic [23:0] r_s1_ur;
    logic [23:0] r_s1_up;
    logic [21:0] r_s1_rr;
    logic        r_s1_fold;
    logic [1:0]  r_s1_q;
    logic [50:0] r_s2_xhi;
    logic [49:0] r_s2_xlo;
    logic [49:0] r_s2_t2;
    logic [48:0] t2_prod;
    logic [24:0] two_up;
    t_smag       n_cp;
    logic [78:0] x_sum;
    t_tq         r_s3_x;
    t_pp         r_s4_xpp;
    t_tq         r_s5_y;
    t_tq         r_xd [20];
    logic [2:0]  r_fq [24];
    t_smag       r_cp [27];

    // trig tail
    t_pp         r_s24_spp;
    t_tq         r_s24_c;
    t_tq         r_s25_s;
    t_tq         r_s25_c;
    t_tq         s_rnd;
    t_tq         c_rnd;
    t_ang        n_ang;
    logic [24:0] sv;
    logic [24:0] cv;
    t_ang        r_s26_ang;
    t_ang        r_ang [4];

    // cell rows
    t_tq                 w_y [N_TRIG+1];
    t_tq                 w_s [N_TRIG+1];
    t_tq                 w_c [N_TRIG+1];
    logic [23:0]         w_cy [N_CBRT+1];
    logic [47:0]         w_cs [N_CBRT+1];
    logic [CB_RW-1:0]    w_cr [N_CBRT+1];
    logic [71:0]         w_ct [N_CBRT+1];
    logic [24:0]         w_qy [N_SQRT+1];
    logic [SQ_RW-1:0]    w_qr [N_SQRT+1];
    logic [49:0]         w_qt [N_SQRT+1];

    // radius and coordinates
    logic [56:0]          cb_lhs;
    logic [56:0]          cb_rhs;
    logic [24:0]          r_s26_cr;
    logic signed [23:0]   diff;
    logic signed [49:0]   rq_prod;
    logic signed [50:0]   rq_sum;
    logic [47:0]          r_s27_rq;
    logic [47:0]          r_s28_rq;
    logic [24:0]          r_s28_sp;
    logic [48:0]          r_s29_ph;
    logic [48:0]          r_s29_pl;
    logic [48:0]          r_s29_zh;
    logic [48:0]          r_s29_zl;
    logic                 r_s29_zneg;
    logic [72:0]          p1_sum;
    logic [72:0]          z_sum;
    logic [71:0]          r_s30_p1;
    logic [23:0]          r_s30_z;
    logic                 r_s30_zneg;
    logic [48:0]          r_s31_xp [3];
    logic [48:0]          r_s31_yp [3];
    logic [23:0]          r_s31_z;
    logic                 r_s31_zneg;
    logic                 r_s31_xneg;
    logic                 r_s31_yneg;
    logic [96:0]          x_sum97;
    logic [96:0]          y_sum97;
    logic [23:0]          x_mag;
    logic [23:0]          y_mag;
    logic [COORD_BITS-1:0] r_px;
    logic [COORD_BITS-1:0] r_py;
    logic [COORD_BITS-1:0] r_pz;

    assign en            = !r_vld[PIPE_DEPTH] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[PIPE_DEPTH];
    assign m_axis_tdata  = {r_pz, r_py, r_px};

    assign in_ur = s_axis_tdata[23:0];
    assign in_ua = s_axis_tdata[47:24];
    assign in_up = s_axis_tdata[71:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_outer <= '0;
            r_inner <= '0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[PIPE_DEPTH-1:1], s_axis_tvalid};
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_OUTER: r_outer <= i_cfg_wdata;
                    REG_INNER: r_inner <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // azimuth folding into the first octant
    always_comb begin
        a2     = {in_ua[22:0], 1'b0};
        a_rem  = a2[21:0];
        n_fold = a_rem > 22'h200000;
        n_rr   = n_fold ? 22'(23'h400000 - {1'b0, a_rem}) : a_rem;
    end

    always_comb begin
        t2_prod    = {25'b0, r_s1_up} * (49'h1000000 - {25'b0, r_s1_up});
        two_up     = {r_s1_up, 1'b0};
        n_cp.neg   = r_s1_up > 24'h800000;
        n_cp.mag   = n_cp.neg ? two_up - 25'h1000000 : 25'h1000000 - two_up;
        x_sum      = {r_s2_xhi, 28'b0} + 79'(r_s2_xlo);
    end

    // rounding, octant swap and quadrant signs
    always_comb begin
        s_rnd      = r_s25_s + K_RND;
        c_rnd      = r_s25_c + K_RND;
        sv         = r_fq[23][2] ? c_rnd[56:32] : s_rnd[56:32];
        cv         = r_fq[23][2] ? s_rnd[56:32] : c_rnd[56:32];
        n_ang.c.mag = r_fq[23][0] ? sv : cv;
        n_ang.c.neg = r_fq[23][0] ^ r_fq[23][1];
        n_ang.s.mag = r_fq[23][0] ? cv : sv;
        n_ang.s.neg = r_fq[23][1];
    end

    always_comb begin
        cb_lhs  = 57'({w_cs[N_CBRT], 3'b000}) + 57'({w_cs[N_CBRT], 2'b00})
                + 57'({w_cy[N_CBRT], 2'b00}) + 57'({w_cy[N_CBRT], 1'b0}) + 57'd1;
        cb_rhs  = 57'({w_cr[N_CBRT], 3'b000});
        diff    = $signed({1'b0, r_outer}) - $signed({1'b0, r_inner});
        rq_prod = $signed({1'b0, r_s26_cr}) * diff;
        rq_sum  = 51'($signed({1'b0, r_inner, 24'b0})) + 51'(rq_prod);
        p1_sum  = {r_s29_ph, 24'b0} + 73'(r_s29_pl);
        z_sum   = {r_s29_zh, 24'b0} + 73'(r_s29_zl);
        x_sum97 = {r_s31_xp[2], 48'b0} + 97'({r_s31_xp[1], 24'b0}) + 97'(r_s31_xp[0]);
        y_sum97 = {r_s31_yp[2], 48'b0} + 97'({r_s31_yp[1], 24'b0}) + 97'(r_s31_yp[0]);
        x_mag   = x_sum97[95:72];
        y_mag   = y_sum97[95:72];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ur   <= in_ur;
            r_s1_up   <= in_up;
            r_s1_rr   <= n_rr;
            r_s1_fold <= n_fold;
            r_s1_q    <= a2[23:22];

            r_s2_xhi  <= K_PI_HALF[56:28] * r_s1_rr;
            r_s2_xlo  <= K_PI_HALF[27:0] * r_s1_rr;
            r_s2_t2   <= {t2_prod[47:0], 2'b00};
            r_fq[0]   <= {r_s1_fold, r_s1_q};
            r_cp[0]   <= n_cp;
            for (int k = 1; k < 24; k++) begin
                r_fq[k] <= r_fq[k-1];
            end
            for (int k = 1; k < 27; k++) begin
                r_cp[k] <= r_cp[k-1];
            end

            r_s3_x   <= t_tq'(x_sum[78:22]);
            r_s4_xpp <= f_mul_pp(r_s3_x, r_s3_x);
            r_xd[0]  <= r_s3_x;
            for (int k = 1; k < 20; k++) begin
                r_xd[k] <= r_xd[k-1];
            end
            r_s5_y   <= f_mul_sum(r_s4_xpp);

            r_s24_spp <= f_mul_pp(r_xd[19], w_s[N_TRIG]);
            r_s24_c   <= w_c[N_TRIG];
            r_s25_s   <= f_mul_sum(r_s24_spp);
            r_s25_c   <= r_s24_c;
            r_s26_ang <= n_ang;
            r_ang[0]  <= r_s26_ang;
            for (int k = 1; k < 4; k++) begin
                r_ang[k] <= r_ang[k-1];
            end

            r_s26_cr <= {1'b0, w_cy[N_CBRT]} + 25'(cb_lhs <= cb_rhs);
            r_s27_rq <= rq_sum[47:0];
            r_s28_rq <= r_s27_rq;
            r_s28_sp <= w_qy[N_SQRT] + 25'({3'b0, w_qy[N_SQRT]} < w_qr[N_SQRT]);

            r_s29_ph   <= r_s28_rq[47:24] * r_s28_sp;
            r_s29_pl   <= r_s28_rq[23:0] * r_s28_sp;
            r_s29_zh   <= r_s28_rq[47:24] * r_cp[26].mag;
            r_s29_zl   <= r_s28_rq[23:0] * r_cp[26].mag;
            r_s29_zneg <= r_cp[26].neg;

            r_s30_p1   <= p1_sum[71:0];
            r_s30_z    <= z_sum[71:48];
            r_s30_zneg <= r_s29_zneg;

            r_s31_xp[2] <= r_s30_p1[71:48] * r_ang[3].c.mag;
            r_s31_xp[1] <= r_s30_p1[47:24] * r_ang[3].c.mag;
            r_s31_xp[0] <= r_s30_p1[23:0] * r_ang[3].c.mag;
            r_s31_yp[2] <= r_s30_p1[71:48] * r_ang[3].s.mag;
            r_s31_yp[1] <= r_s30_p1[47:24] * r_ang[3].s.mag;
            r_s31_yp[0] <= r_s30_p1[23:0] * r_ang[3].s.mag;
            r_s31_xneg  <= r_ang[3].c.neg;
            r_s31_yneg  <= r_ang[3].s.neg;
            r_s31_z     <= r_s30_z;
            r_s31_zneg  <= r_s30_zneg;

            r_px <= r_s31_xneg ? -x_mag : x_mag;
            r_py <= r_s31_yneg ? -y_mag : y_mag;
            r_pz <= r_s31_zneg ? -r_s31_z : r_s31_z;
        end
    end

    // sine / cosine horner row
    assign w_y[0] = r_s5_y;
    assign w_s[0] = K_COEF[19];
    assign w_c[0] = K_COEF[18];

    for (genvar j = 0; j < N_TRIG; j++) begin : g_trig
        ssps_trig_cell u_cell (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_y      (w_y[j]),
            .i_acc_s  (w_s[j]),
            .i_acc_c  (w_c[j]),
            .i_coef_s (K_COEF[17-2*j]),
            .i_coef_c (K_COEF[16-2*j]),
            .o_y      (w_y[j+1]),
            .o_acc_s  (w_s[j+1]),
            .o_acc_c  (w_c[j+1])
        );
    end

    // cube root row
    assign w_cy[0] = '0;
    assign w_cs[0] = '0;
    assign w_cr[0] = '0;
    assign w_ct[0] = {r_s1_ur, 48'b0};

    for (genvar j = 0; j < N_CBRT; j++) begin : g_cbrt
        ssps_cbrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_y   (w_cy[j]),
            .i_s   (w_cs[j]),
            .i_r   (w_cr[j]),
            .i_t   (w_ct[j]),
            .o_y   (w_cy[j+1]),
            .o_s   (w_cs[j+1]),
            .o_r   (w_cr[j+1]),
            .o_t   (w_ct[j+1])
        );
    end

    // square root row
    assign w_qy[0] = '0;
    assign w_qr[0] = '0;
    assign w_qt[0] = r_s2_t2;

    for (genvar j = 0; j < N_SQRT; j++) begin : g_sqrt
        ssps_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_y   (w_qy[j]),
            .i_r   (w_qr[j]),
            .i_t   (w_qt[j]),
            .o_y   (w_qy[j+1]),
            .o_r   (w_qr[j+1]),
            .o_t   (w_qt[j+1])
        );
    end

endmodule

// File: rtl/ssps_cbrt_cell.sv
// ----------------------------------------------------------------------------
// ssps_cbrt_cell
// one bit of a pipelined digit-by-digit cube root
// ----------------------------------------------------------------------------
module ssps_cbrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [23:0]                 i_y,
    input  logic [47:0]                 i_s,
    input  logic [ssps_pkg::CB_RW-1:0]  i_r,
    input  logic [71:0]                 i_t,
    output logic [23:0]                 o_y,
    output logic [47:0]                 o_s,
    output logic [ssps_pkg::CB_RW-1:0]  o_r,
    output logic [71:0]                 o_t
);
    import ssps_pkg::*;

    logic [23:0]      y2;
    logic [47:0]      s2;
    logic [CB_RW-1:0] rw;
    logic [CB_RW-1:0] trial;
    logic             take;
    logic [23:0]      n_y;
    logic [47:0]      n_s;
    logic [CB_RW-1:0] n_r;

    always_comb begin
        y2    = {i_y[22:0], 1'b0};
        s2    = {i_s[45:0], 2'b00};
        rw    = {i_r[CB_RW-4:0], i_t[71:69]};
        trial = CB_RW'({s2, 1'b0}) + CB_RW'(s2) + CB_RW'({y2, 1'b0}) + CB_RW'(y2)
              + CB_RW'(1);
        take  = rw >= trial;
        n_y   = {y2[23:1], take};
        n_s   = take ? s2 + 48'({y2, 1'b1}) : s2;
        n_r   = take ? rw - trial : rw;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y <= n_y;
            o_s <= n_s;
            o_r <= n_r;
            o_t <= {i_t[68:0], 3'b000};
        end
    end

endmodule

// File: rtl/ssps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ssps_sqrt_cell
// one bit of a pipelined digit-by-digit square root
// ----------------------------------------------------------------------------
module ssps_sqrt_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [24:0]                 i_y,
    input  logic [ssps_pkg::SQ_RW-1:0]  i_r,
    input  logic [49:0]                 i_t,
    output logic [24:0]                 o_y,
    output logic [ssps_pkg::SQ_RW-1:0]  o_r,
    output logic [49:0]                 o_t
);
    import ssps_pkg::*;

    logic [SQ_RW-1:0] rw;
    logic [SQ_RW-1:0] trial;
    logic             take;

    always_comb begin
        rw    = {i_r[SQ_RW-3:0], i_t[49:48]};
        trial = SQ_RW'({i_y, 2'b01});
        take  = rw >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y <= {i_y[23:0], take};
            o_r <= take ? rw - trial : rw;
            o_t <= {i_t[47:0], 2'b00};
        end
    end

endmodule

// File: rtl/ssps_trig_cell.sv
// ----------------------------------------------------------------------------
// ssps_trig_cell
// one horner step of the sine and cosine series, two register stages
// ----------------------------------------------------------------------------
module ssps_trig_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  ssps_pkg::t_tq  i_y,
    input  ssps_pkg::t_tq  i_acc_s,
    input  ssps_pkg::t_tq  i_acc_c,
    input  ssps_pkg::t_tq  i_coef_s,
    input  ssps_pkg::t_tq  i_coef_c,
    output ssps_pkg::t_tq  o_y,
    output ssps_pkg::t_tq  o_acc_s,
    output ssps_pkg::t_tq  o_acc_c
);
    import ssps_pkg::*;

    t_pp r_pp_s;
    t_pp r_pp_c;
    t_tq r_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_s  <= f_mul_pp(i_acc_s, i_y);
            r_pp_c  <= f_mul_pp(i_acc_c, i_y);
            r_y     <= i_y;
            o_acc_s <= i_coef_s - f_mul_sum(r_pp_s);
            o_acc_c <= i_coef_c - f_mul_sum(r_pp_c);
            o_y     <= r_y;
        end
    end

endmodule

// File: rtl/ssps_checker.sv
// ----------------------------------------------------------------------------
// ssps_checker
// port-level checks for the spherical shell point sampler
// ----------------------------------------------------------------------------
module ssps_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic [ssps_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input logic [ssps_pkg::RAD_BITS-1:0]     i_cfg_wdata,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ssps_pkg::IN_W-1:0]         s_axis_tdata,  // u_radius, u_azimuth, u_polar
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ssps_pkg::OUT_W-1:0]        m_axis_tdata   // pos_x, pos_y, pos_z
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request blocked with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while pipeline held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");

endmodule

bind spherical_shell_point_sampler ssps_checker u_ssps_checker (.*);
